/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define SSML_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SSML_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/ssml_pkg.sv */
`default_nettype none
package ssml_pkg;

  localparam int MAX_LEN     = 4095;
  localparam int VALUE_WIDTH = 32;
  localparam int IN_W        = 32;
  localparam int SUM_W       = 48;
  localparam int OUT_LEN_W   = 12;
  localparam int OUT_LEN_MAX = (1 << OUT_LEN_W) - 1;

  localparam int DEPTH   = MAX_LEN + 1;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int BEST_W  = $clog2(MAX_LEN + 2);
  localparam int ENTRY_W = SUM_W + ADDR_W;

  // power of two
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic [ADDR_W-1:0]       pos_t;

  // one classified word on its way from front to back
  typedef struct packed {
    sum_t sum;
    pos_t pos;
    logic last;
    logic ign;
  } fq_t;

  localparam sum_t THR_RESET = SUM_W'(1);

endpackage
`default_nettype wire

/* hw/rtl/ssml_in_if.sv */
`default_nettype none
interface ssml_in_if;
  logic                      valid;
  logic                      ready;
  logic [ssml_pkg::IN_W-1:0] value;
  logic                      last_item;

  modport source(output valid, value, last_item, input ready);
  modport sink(input valid, value, last_item, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ssml_out_if.sv */
`default_nettype none
interface ssml_out_if;
  logic                           valid;
  logic                           ready;
  logic                           found;
  logic [ssml_pkg::OUT_LEN_W-1:0] shortest_length;
  logic                           too_long;

  modport source(output valid, found, shortest_length, too_long, input ready);
  modport sink(input valid, found, shortest_length, too_long, output ready);
endinterface
`default_nettype wire

/* hw/rtl/ssml_ram.sv */
`default_nettype none
// 1W/2R RAM, registered reads, write-first on address match.
module ssml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_a_r <= (we && (waddr == raddr_a)) ? wdata : mem_r[raddr_a];
    rd_b_r <= (we && (waddr == raddr_b)) ? wdata : mem_r[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;

endmodule
`default_nettype wire

/* hw/rtl/ssml_front.sv */
`default_nettype none
// Prefix sum, position count and overflow classification per word.
module ssml_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ssml_in_if.sink          in_s,
  input  wire logic        q_full,
  output logic             q_push,
  output ssml_pkg::fq_t    q_data
);

  ssml_pkg::sum_t prefix_r, prefix_nxt;
  ssml_pkg::pos_t pos_r, pos_nxt;
  ssml_pkg::sum_t val_ext;
  ssml_pkg::sum_t cur_sum;
  ssml_pkg::pos_t pos_inc;
  logic           ign;

  assign in_s.ready = !q_full;
  assign q_push     = in_s.valid && !q_full;

  assign val_ext = ssml_pkg::SUM_W'(signed'(in_s.value[ssml_pkg::VALUE_WIDTH-1:0]));
  assign cur_sum = prefix_r + val_ext;
  assign pos_inc = pos_r + ssml_pkg::pos_t'(1);
  // sequence already holds the maximum count: drop the value
  assign ign     = pos_r >= ssml_pkg::pos_t'(ssml_pkg::MAX_LEN);

  always_comb begin
    q_data.sum  = ign ? prefix_r : cur_sum;
    q_data.pos  = ign ? pos_r : pos_inc;
    q_data.last = in_s.last_item;
    q_data.ign  = ign;
  end

  always_comb begin
    prefix_nxt = prefix_r;
    pos_nxt    = pos_r;
    if (q_push) begin
      if (in_s.last_item) begin
        prefix_nxt = '0;
        pos_nxt    = '0;
      end else if (!ign) begin
        prefix_nxt = cur_sum;
        pos_nxt    = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= '0;
      pos_r    <= '0;
    end else begin
      prefix_r <= prefix_nxt;
      pos_r    <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ssml_fifo.sv */
`default_nettype none
// Short queue between front and back.
module ssml_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire ssml_pkg::fq_t  din,
  output logic                full,
  input  wire logic           pop,
  output ssml_pkg::fq_t       dout,
  output logic                empty
);

  ssml_pkg::fq_t                   mem_r [ssml_pkg::FIFO_DEPTH];
  logic [ssml_pkg::FIFO_PTR_W-1:0] wp_r, wp_nxt;
  logic [ssml_pkg::FIFO_PTR_W-1:0] rp_r, rp_nxt;
  logic [ssml_pkg::FIFO_PTR_W:0]   cnt_r, cnt_nxt;

  assign full  = cnt_r == (ssml_pkg::FIFO_PTR_W+1)'(ssml_pkg::FIFO_DEPTH);
  assign empty = cnt_r == '0;
  assign dout  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ssml_back.sv */
`default_nettype none
`include "assert_macros.svh"
// Deque engine: front pops, back pops, push, result and clear.
module ssml_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire ssml_pkg::sum_t thr,
  input  wire ssml_pkg::fq_t  q_data,
  input  wire logic           q_empty,
  output logic                q_pop,
  ssml_out_if.source          out_s
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FRONT = 3'd2;
  localparam logic [2:0] ST_BACK  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam int SW = ssml_pkg::SUM_W;
  localparam int AW = ssml_pkg::ADDR_W;
  localparam int FW = ssml_pkg::FILL_W;
  localparam int BW = ssml_pkg::BEST_W;
  localparam int EW = ssml_pkg::ENTRY_W;
  localparam int LW = ssml_pkg::OUT_LEN_W;
  localparam logic [BW-1:0] BEST_NONE = BW'(ssml_pkg::MAX_LEN + 1);

  logic [2:0]     state_r, state_nxt;
  ssml_pkg::pos_t head_r, head_nxt;
  logic [FW-1:0]  fill_r, fill_nxt;
  logic [BW-1:0]  best_r, best_nxt;
  logic           ovf_r, ovf_nxt;
  ssml_pkg::sum_t cur_sum_r, cur_sum_nxt;
  ssml_pkg::pos_t cur_pos_r, cur_pos_nxt;
  logic           cur_last_r, cur_last_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_found_r, out_found_nxt;
  logic [LW-1:0]  out_len_r, out_len_nxt;
  logic           out_tl_r, out_tl_nxt;

  logic           we_w;
  ssml_pkg::pos_t waddr_w;
  logic [EW-1:0]  wdata_w;
  ssml_pkg::pos_t raddr_b_w;
  logic [FW-1:0]  bidx_w;
  logic [FW-1:0]  slot_w;
  logic [EW-1:0]  rd_a, rd_b;
  ssml_pkg::sum_t f_sum, b_sum;
  ssml_pkg::pos_t f_pos;
  logic signed [SW:0] diff_w, thr_x;
  ssml_pkg::pos_t span_w;
  logic           front_hit, back_hit;
  logic           do_take;
  logic           emit_go;
  logic           found_w;

  // reads follow the next pointers so data is ready in the following cycle
  assign bidx_w    = FW'(head_nxt) + fill_nxt - FW'(1);
  assign raddr_b_w = bidx_w[AW-1:0];
  assign slot_w    = FW'(head_r) + fill_r;

  ssml_ram #(
    .WIDTH(EW),
    .DEPTH(ssml_pkg::DEPTH)
  ) u_deque (
    .clk    (clk),
    .we     (we_w),
    .waddr  (waddr_w),
    .wdata  (wdata_w),
    .raddr_a(head_nxt),
    .rdata_a(rd_a),
    .raddr_b(raddr_b_w),
    .rdata_b(rd_b)
  );

  assign f_sum = rd_a[EW-1 -: SW];
  assign f_pos = rd_a[AW-1:0];
  assign b_sum = rd_b[EW-1 -: SW];

  assign diff_w    = (SW+1)'(cur_sum_r) - (SW+1)'(f_sum);
  assign thr_x     = (SW+1)'(thr);
  assign front_hit = (fill_r != '0) && (diff_w >= thr_x);
  assign span_w    = cur_pos_r - f_pos;
  assign back_hit  = (fill_r != '0) && (b_sum >= cur_sum_r);
  assign emit_go   = !out_valid_r || out_s.ready;
  assign found_w   = best_r <= BW'(ssml_pkg::MAX_LEN);

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    fill_nxt      = fill_r;
    best_nxt      = best_r;
    ovf_nxt       = ovf_r;
    cur_sum_nxt   = cur_sum_r;
    cur_pos_nxt   = cur_pos_r;
    cur_last_nxt  = cur_last_r;
    out_valid_nxt = out_valid_r && !out_s.ready;
    out_found_nxt = out_found_r;
    out_len_nxt   = out_len_r;
    out_tl_nxt    = out_tl_r;
    we_w          = 1'b0;
    waddr_w       = slot_w[AW-1:0];
    wdata_w       = {cur_sum_r, cur_pos_r};
    do_take       = 1'b0;
    q_pop         = 1'b0;

    case (state_r)
      ST_INIT: begin
        // seed entry: position 0, sum 0
        we_w      = 1'b1;
        waddr_w   = '0;
        wdata_w   = '0;
        head_nxt  = '0;
        fill_nxt  = FW'(1);
        best_nxt  = BEST_NONE;
        ovf_nxt   = 1'b0;
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        do_take = !q_empty;
      end
      ST_FRONT: begin
        if (front_hit) begin
          if (BW'(span_w) < best_r) begin
            best_nxt = BW'(span_w);
          end
          head_nxt = head_r + ssml_pkg::pos_t'(1);
          fill_nxt = fill_r - FW'(1);
        end else if (cur_last_r) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_BACK;
        end
      end
      ST_BACK: begin
        if (back_hit) begin
          fill_nxt = fill_r - FW'(1);
        end else begin
          we_w      = 1'b1;
          fill_nxt  = fill_r + FW'(1);
          state_nxt = ST_IDLE;
          do_take   = !q_empty;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_w;
          out_tl_nxt    = ovf_r;
          if (!found_w) begin
            out_len_nxt = '0;
          end else if (32'(best_r) > 32'(ssml_pkg::OUT_LEN_MAX)) begin
            out_len_nxt = LW'(ssml_pkg::OUT_LEN_MAX);
          end else begin
            out_len_nxt = LW'(best_r);
          end
          we_w      = 1'b1;
          waddr_w   = '0;
          wdata_w   = '0;
          head_nxt  = '0;
          fill_nxt  = FW'(1);
          best_nxt  = BEST_NONE;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase

    if (do_take) begin
      q_pop = 1'b1;
      if (q_data.ign) begin
        ovf_nxt   = 1'b1;
        state_nxt = q_data.last ? ST_EMIT : ST_IDLE;
      end else begin
        cur_sum_nxt  = q_data.sum;
        cur_pos_nxt  = q_data.pos;
        cur_last_nxt = q_data.last;
        state_nxt    = ST_FRONT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      head_r      <= '0;
      fill_r      <= FW'(1);
      best_r      <= BEST_NONE;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      best_r      <= best_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_sum_r   <= cur_sum_nxt;
    cur_pos_r   <= cur_pos_nxt;
    cur_last_r  <= cur_last_nxt;
    out_found_r <= out_found_nxt;
    out_len_r   <= out_len_nxt;
    out_tl_r    <= out_tl_nxt;
  end

  assign out_s.valid           = out_valid_r;
  assign out_s.found           = out_found_r;
  assign out_s.shortest_length = out_len_r;
  assign out_s.too_long        = out_tl_r;

  `SSML_ASSERT(a_fill_bound, clk, rst_n,
    fill_r <= FW'(ssml_pkg::DEPTH), "deque fill past depth")
  `SSML_ASSERT(a_push_range, clk, rst_n,
    (we_w && state_r == ST_BACK) |-> (slot_w < FW'(ssml_pkg::DEPTH)),
    "push slot out of range")
  `SSML_ASSERT(a_best_mono, clk, rst_n,
    (state_r == ST_FRONT) |=> (best_r <= $past(best_r)),
    "best length grew during front pops")
  `SSML_ASSERT(a_ign_skip, clk, rst_n,
    (q_pop && q_data.ign) |=> (state_r != ST_FRONT),
    "dropped word entered deque work")

endmodule
`default_nettype wire

/* hw/rtl/shortest_subarray_min_sum_length_core.sv */
// Per word the deque engine does a front check and a push, plus one step per front or
//   back pop; each position is popped at most once. An idle step follows each emitted
//   result and each time the queue has run dry.
// Result: after the last word its front pops run, then the emit state registers the result.
// Reset (rst_n low, synchronous): clears control state; threshold reads 1. Leaving reset,
//   the engine seeds deque entry 0 in its init state; input words are queued meanwhile.
`default_nettype none
module shortest_subarray_min_sum_length_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  ssml_in_if.sink                        in_s,
  ssml_out_if.source                     out_s,
  input  wire logic                      cfg_we,
  input  wire logic [ssml_pkg::SUM_W-1:0] cfg_wdata
);

  // threshold: least span sum that counts
  ssml_pkg::sum_t thr_r, thr_nxt;

  // front -> queue -> back
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  ssml_pkg::fq_t q_in;
  ssml_pkg::fq_t q_out;

  assign thr_nxt = cfg_we ? ssml_pkg::sum_t'(cfg_wdata) : thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ssml_pkg::THR_RESET;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  // front: running prefix sum, position, drop of words past the max length
  ssml_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (in_s),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_in)
  );

  // two-word queue so the front keeps taking words while the deque pops
  ssml_fifo u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  (q_in),
    .full (q_full),
    .pop  (q_pop),
    .dout (q_out),
    .empty(q_empty)
  );

  // back: monotonic deque in RAM, shortest span tracking, result register
  ssml_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .thr    (thr_r),
    .q_data (q_out),
    .q_empty(q_empty),
    .q_pop  (q_pop),
    .out_s  (out_s)
  );

endmodule
`default_nettype wire
